// ===== rtl/core/biq_pkg.sv =====
// Shared types, constants and helper functions for the biquad cascade filter.
package biq_pkg;

	// Cascade size and number formats.
	localparam int SECTIONS    = 2;
	localparam int COEF_BITS   = 24;
	localparam int FRAC_BITS   = 20;
	localparam int SAMPLE_W    = 32;
	localparam int DATA_W      = 56;
	localparam int ACC_W       = DATA_W + 2;
	localparam int Q_W         = DATA_W - FRAC_BITS;
	localparam int SEC_W       = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
	localparam int DELAY_DEPTH = 2 * SECTIONS;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int TERMS       = 5;

	// Shared multiplier: coefficient magnitude times one 32-bit slice of the data magnitude.
	localparam int MUL_B_W  = 32;
	localparam int PROD_W   = COEF_BITS + MUL_B_W;
	localparam int HI_W     = COEF_BITS + DATA_W - MUL_B_W;
	localparam int HI_SHIFT = MUL_B_W - FRAC_BITS;
	localparam int HI_KEEP  = DATA_W - 1 - HI_SHIFT;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2 * COEF_BITS;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_SEC0_B0_B1 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC0_B2_A1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC0_A2    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC1_B0_B1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC1_B2_A1 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SEC1_A2    = 3'd5;

	// Saturation limits and constants of the data path.
	localparam logic [DATA_W-1:0] D_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] D_MIN = {1'b1, {(DATA_W-1){1'b0}}};
	localparam logic [DATA_W-1:0] RND_BIAS = DATA_W'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(64'd1 << FRAC_BITS);

	// Products of one section, in the order they are computed.
	typedef enum logic [2:0] {
		T_B0X,
		T_B1X,
		T_A1Y,
		T_B2X,
		T_A2Y
	} term_t;

	// Register layout within one section.
	typedef enum logic [1:0] {
		KIND_B0_B1,
		KIND_B2_A1,
		KIND_A2
	} cfg_kind_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_RD0,
		S_RD1,
		S_LOAD,
		S_WAIT,
		S_OUT
	} state_t;

	typedef struct packed {
		logic                  en;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic             hit;
		logic [SEC_W-1:0] sec;
		cfg_kind_t        kind;
	} cfg_dec_t;

	typedef struct packed {
		logic                 start;
		logic [COEF_BITS-1:0] coef;
		logic [DATA_W-1:0]    value;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic              neg;
		logic [DATA_W-1:0] mag;
		logic              sat;
	} mul_rsp_t;

	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [DATA_W-1:0] wr_data;
	} mem_req_t;

	typedef struct packed {
		logic [DATA_W-1:0] val;
		logic              sat;
	} dsat_t;

	// Map a register index to its section and layout; indexes past the list miss.
	function automatic cfg_dec_t cfg_decode(input logic [CFG_IDX_W-1:0] idx);
		cfg_dec_t d;
		int       sec_n;
		d.hit  = 1'b1;
		d.kind = KIND_B0_B1;
		sec_n  = 0;
		case (idx)
			CFG_SEC0_B0_B1: begin
				sec_n  = 0;
				d.kind = KIND_B0_B1;
			end
			CFG_SEC0_B2_A1: begin
				sec_n  = 0;
				d.kind = KIND_B2_A1;
			end
			CFG_SEC0_A2: begin
				sec_n  = 0;
				d.kind = KIND_A2;
			end
			CFG_SEC1_B0_B1: begin
				sec_n  = 1;
				d.kind = KIND_B0_B1;
			end
			CFG_SEC1_B2_A1: begin
				sec_n  = 1;
				d.kind = KIND_B2_A1;
			end
			CFG_SEC1_A2: begin
				sec_n  = 1;
				d.kind = KIND_A2;
			end
			default: begin
				d.hit = 1'b0;
			end
		endcase
		if (sec_n >= SECTIONS) begin
			d.hit = 1'b0;
			sec_n = 0;
		end
		d.sec = SEC_W'(sec_n);
		return d;
	endfunction

	// Product that follows the given one within a section.
	function automatic term_t term_next(input term_t t);
		term_t n;
		case (t)
			T_B0X:   n = T_B1X;
			T_B1X:   n = T_A1Y;
			T_A1Y:   n = T_B2X;
			T_B2X:   n = T_A2Y;
			default: n = T_B0X;
		endcase
		return n;
	endfunction

	// Clip an accumulator value to the signed delay-state range.
	function automatic dsat_t sat_data(input logic [ACC_W-1:0] v);
		dsat_t r;
		r.sat = 1'b0;
		r.val = v[DATA_W-1:0];
		if (!v[ACC_W-1] && (|v[ACC_W-2:DATA_W-1])) begin
			r.sat = 1'b1;
			r.val = D_MAX;
		end else if (v[ACC_W-1] && !(&v[ACC_W-2:DATA_W-1])) begin
			r.sat = 1'b1;
			r.val = D_MIN;
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/biquad_cascade_iir_filter.sv =====
// Top level of the biquad cascade filter: sequencer, accumulator and output register.
//
// Each request carries one signed 32-bit sample through SECTIONS second-order sections in
// transposed direct form II (a0 is one), with signed Q4.20 coefficients and 56-bit Q.20 delay
// state that saturates; the result is truncated toward zero and clipped to 32 bits, and the
// saturated flag reports any clipping along the way. Items are handled one at a time: the
// request is held off while the single 24 x 32 multiplier runs each of the five products of a
// section over two slices, one product after another, and while the two reads of a section's
// delay values come from the state memory. A finished result waits in the output register
// and does not hold up the next request. Coefficient registers are to be written by the user
// through the configuration port only while the filter is idle; the block itself does not
// enforce this. Writes to indexes past the list are ignored.
module biquad_cascade_iir_filter import biq_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [SAMPLE_W-1:0]   sample_in,
	input  logic                  block_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SAMPLE_W-1:0]   sample_out,
	output logic                  block_last_out,
	output logic                  saturated,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t               state_q, state_d;
	logic [SEC_W-1:0]     sec_q;
	term_t                term_q;
	term_t                issue_term;
	logic [DATA_W-1:0]    x_q, y_q, d1_q;
	logic [ACC_W-1:0]     acc_q;
	logic                 sat_q;
	logic                 last_q;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  sample_out_q;
	logic                 block_last_out_q;
	logic                 saturated_q;

	cfg_wr_t              cfg_wr;
	mul_req_t             mul_req;
	mul_rsp_t             mul_rsp;
	mem_req_t             mem_req;
	logic [DATA_W-1:0]    mem_rd_data;
	logic [COEF_BITS-1:0] coef_rd;

	logic                 in_accept;
	logic                 out_load;
	logic                 last_sec;
	logic [ADDR_W-1:0]    addr_d0, addr_d1;
	logic                 sub_term;
	logic                 flip;
	logic [ACC_W-1:0]     addend;
	logic [ACC_W-1:0]     acc_sum;
	dsat_t                acc_sat;
	logic [DATA_W-1:0]    rnd;
	logic [Q_W-1:0]       q_int;
	logic                 q_hi, q_lo;
	logic [SAMPLE_W-1:0]  q_clip;

	// The configuration port is always ready; writes are to come only while idle, which the block does not enforce.
	assign cfg_ready    = 1'b1;
	assign cfg_wr.en    = cfg_valid;
	assign cfg_wr.index = cfg_index;
	assign cfg_wr.data  = cfg_data;

	biq_coef_regs u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_wr  (cfg_wr),
		.rd_sec  (sec_q),
		.rd_term (issue_term),
		.rd_coef (coef_rd)
	);

	biq_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	biq_delay_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mem_req),
		.rd_data (mem_rd_data)
	);

	// Handshake conditions.
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_load  = (state_q == S_OUT) && (!out_valid_q || !out_stall);

	// Delay addresses of the current section and the product to start next.
	assign last_sec   = (sec_q == SEC_W'(SECTIONS - 1));
	assign addr_d0    = ADDR_W'({sec_q, 1'b0});
	assign addr_d1    = ADDR_W'({sec_q, 1'b1});
	assign issue_term = (state_q == S_WAIT) ? term_next(term_q) : T_B0X;

	// Feedback products are subtracted; the product sign comes in magnitude form.
	assign sub_term = (term_q == T_A1Y) || (term_q == T_A2Y);
	assign flip     = mul_rsp.neg ^ sub_term;
	assign addend   = ACC_W'(mul_rsp.mag);
	assign acc_sum  = acc_q + (flip ? ~addend : addend) + ACC_W'(flip);
	assign acc_sat  = sat_data(acc_sum);

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state, memory accesses and multiplier starts.
	always_comb begin
		state_d         = state_q;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = addr_d0;
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = addr_d0;
		mem_req.wr_data = acc_sat.val;
		mul_req.start   = 1'b0;
		// Multiplier operands: feedback terms take the section output.
		mul_req.coef    = coef_rd;
		mul_req.value   = ((issue_term == T_A1Y) || (issue_term == T_A2Y)) ? y_q : x_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_RD0;
				end
			end
			S_RD0: begin
				mem_req.rd_en = 1'b1;
				state_d       = S_RD1;
			end
			S_RD1: begin
				mem_req.rd_en   = 1'b1;
				mem_req.rd_addr = addr_d1;
				state_d         = S_LOAD;
			end
			S_LOAD: begin
				mul_req.start = 1'b1;
				state_d       = S_WAIT;
			end
			S_WAIT: begin
				if (mul_rsp.done) begin
					if (term_q == T_A1Y) begin
						mem_req.wr_en = 1'b1;
					end
					if (term_q == T_A2Y) begin
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = addr_d1;
						state_d         = last_sec ? S_OUT : S_RD0;
					end else begin
						mul_req.start = 1'b1;
					end
				end
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Section and product counters, and the per-item saturation flag.
	// Partial sums inside a delay update are not clipped, so only finished sums count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sec_q  <= '0;
			term_q <= T_B0X;
			sat_q  <= 1'b0;
		end else begin
			if (in_accept) begin
				sec_q <= '0;
				sat_q <= 1'b0;
			end else if (state_q == S_WAIT && mul_rsp.done) begin
				sat_q <= sat_q | mul_rsp.sat
					| (acc_sat.sat && (term_q != T_B1X) && (term_q != T_B2X));
				if (term_q == T_A2Y && !last_sec) begin
					sec_q <= sec_q + 1'b1;
				end
			end
			if (mul_req.start) begin
				term_q <= issue_term;
			end
		end
	end

	// Sample, section output and accumulator.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			x_q    <= {{(DATA_W-SAMPLE_W-FRAC_BITS){sample_in[SAMPLE_W-1]}}, sample_in,
				{FRAC_BITS{1'b0}}};
			last_q <= block_last;
		end
		case (state_q)
			S_RD1: begin
				acc_q <= {{(ACC_W-DATA_W){mem_rd_data[DATA_W-1]}}, mem_rd_data};
			end
			S_LOAD: begin
				d1_q <= mem_rd_data;
			end
			S_WAIT: begin
				if (mul_rsp.done) begin
					case (term_q)
						T_B0X: begin
							y_q   <= acc_sat.val;
							acc_q <= {{(ACC_W-DATA_W){d1_q[DATA_W-1]}}, d1_q};
						end
						T_A1Y: begin
							acc_q <= '0;
						end
						T_A2Y: begin
							x_q <= y_q;
						end
						default: begin
							acc_q <= acc_sum;
						end
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	// Final output: truncate toward zero, then clip to the sample range.
	assign rnd    = x_q + (x_q[DATA_W-1] ? RND_BIAS : '0);
	assign q_int  = rnd[DATA_W-1:FRAC_BITS];
	assign q_hi   = !q_int[Q_W-1] && (|q_int[Q_W-2:SAMPLE_W-1]);
	assign q_lo   = q_int[Q_W-1] && !(&q_int[Q_W-2:SAMPLE_W-1]);
	assign q_clip = q_hi ? {1'b0, {(SAMPLE_W-1){1'b1}}} :
		q_lo ? {1'b1, {(SAMPLE_W-1){1'b0}}} : q_int[SAMPLE_W-1:0];

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			sample_out_q     <= q_clip;
			block_last_out_q <= last_q;
			saturated_q      <= sat_q | q_hi | q_lo;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_out     = sample_out_q;
	assign block_last_out = block_last_out_q;
	assign saturated      = saturated_q;

`ifndef NO_ASSERTIONS
	// The state memory never sees a read and a write in the same cycle.
	a_mem_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.rd_en && mem_req.wr_en))
		else $error("delay memory read and write collide");

	// Multiplier results arrive only while the sequencer waits for them.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_WAIT))
		else $error("multiplier result outside the wait state");

	// While waiting, a new product starts only as the previous one completes.
	a_start_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_req.start && state_q == S_WAIT) |-> mul_rsp.done)
		else $error("multiplier started while busy");

	// An accepted request begins with the first delay read.
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_RD0))
		else $error("accepted request did not start the section sweep");
`endif

endmodule

// ===== rtl/core/biq_coef_regs.sv =====
// Coefficient register file with configuration decode and one read port.
module biq_coef_regs import biq_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_wr_t              cfg_wr,
	input  logic [SEC_W-1:0]     rd_sec,
	input  term_t                rd_term,
	output logic [COEF_BITS-1:0] rd_coef
);

	logic [COEF_BITS-1:0] coef_q [SECTIONS][TERMS];
	cfg_dec_t             dec;

	assign dec = cfg_decode(cfg_wr.index);

	// Coefficients come up as a pass-through section: b0 is one, the rest zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < SECTIONS; s++) begin
				for (int t = 0; t < TERMS; t++) begin
					coef_q[s][t] <= (t == int'(T_B0X)) ? COEF_ONE : '0;
				end
			end
		end else if (cfg_wr.en && dec.hit) begin
			case (dec.kind)
				KIND_B0_B1: begin
					coef_q[dec.sec][T_B0X] <= cfg_wr.data[CFG_DATA_W-1:COEF_BITS];
					coef_q[dec.sec][T_B1X] <= cfg_wr.data[COEF_BITS-1:0];
				end
				KIND_B2_A1: begin
					coef_q[dec.sec][T_B2X] <= cfg_wr.data[CFG_DATA_W-1:COEF_BITS];
					coef_q[dec.sec][T_A1Y] <= cfg_wr.data[COEF_BITS-1:0];
				end
				KIND_A2: begin
					coef_q[dec.sec][T_A2Y] <= cfg_wr.data[COEF_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Coefficient for the product the sequencer is about to start.
	assign rd_coef = coef_q[rd_sec][rd_term];

endmodule

// ===== rtl/core/biq_mul.sv =====
// Shared fractional multiplier: sign-magnitude product shifted by the fraction bits and clipped.
module biq_mul import biq_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	logic                 hi_ph_q, lo_ph_q, cmb_ph_q, done_q;
	logic [COEF_BITS-1:0] a_q;
	logic [DATA_W-1:0]    b_q;
	logic                 neg_q;
	logic [HI_W-1:0]      hi_q;
	logic [PROD_W-1:0]    lo_q;
	logic [DATA_W-1:0]    mag_q;
	logic                 sat_q;

	logic [COEF_BITS-1:0] a_mag;
	logic [DATA_W-1:0]    b_mag;
	logic [MUL_B_W-1:0]   mul_b;
	logic [PROD_W-1:0]    prod;
	logic [DATA_W-1:0]    m_sum;
	logic [DATA_W-1:0]    limit;
	logic                 over;

	// Phase chain: operands latched, high slice, low slice, combine.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_ph_q  <= 1'b0;
			lo_ph_q  <= 1'b0;
			cmb_ph_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			hi_ph_q  <= req.start;
			lo_ph_q  <= hi_ph_q;
			cmb_ph_q <= lo_ph_q;
			done_q   <= cmb_ph_q;
		end
	end

	// Operand magnitudes and the sign of the product.
	assign a_mag = req.coef[COEF_BITS-1] ? (~req.coef + 1'b1) : req.coef;
	assign b_mag = req.value[DATA_W-1] ? (~req.value + 1'b1) : req.value;

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q   <= a_mag;
			b_q   <= b_mag;
			neg_q <= req.coef[COEF_BITS-1] ^ req.value[DATA_W-1];
		end
	end

	// One multiplier, used for the high slice and then the low slice.
	assign mul_b = hi_ph_q ? MUL_B_W'(b_q[DATA_W-1:MUL_B_W]) : b_q[MUL_B_W-1:0];
	assign prod  = a_q * mul_b;

	always_ff @(posedge clk) begin
		if (hi_ph_q) begin
			hi_q <= prod[HI_W-1:0];
		end
		if (lo_ph_q) begin
			lo_q <= prod;
		end
	end

	// Join the slices, drop the fraction bits and clip to the signed range.
	assign m_sum = {1'b0, hi_q[HI_KEEP-1:0], {HI_SHIFT{1'b0}}}
		+ DATA_W'(lo_q[PROD_W-1:FRAC_BITS]);
	assign limit = neg_q ? D_MIN : D_MAX;
	assign over  = (|hi_q[HI_W-1:HI_KEEP]) || (m_sum > limit);

	always_ff @(posedge clk) begin
		if (cmb_ph_q) begin
			mag_q <= over ? limit : m_sum;
			sat_q <= over;
		end
	end

	assign rsp.done = done_q;
	assign rsp.neg  = neg_q;
	assign rsp.mag  = mag_q;
	assign rsp.sat  = sat_q;

endmodule

// ===== rtl/core/biq_delay_mem.sv =====
// Delay-state memory: one write port, one registered read port, per-entry valid bits.
module biq_delay_mem import biq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mem_req_t          req,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DELAY_DEPTH];
	logic              valid_q [DELAY_DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Entries not yet written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DELAY_DEPTH; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (req.wr_en) begin
			valid_q[req.wr_addr] <= 1'b1;
		end
	end

	// Storage write.
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	// Synchronous read into a registered output.
	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= valid_q[req.rd_addr] ? mem[req.rd_addr] : '0;
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sim/biquad_check_pkg.sv =====
// Predictor and scoreboard of the biquad cascade filter, with the test's shared types.
package biquad_check_pkg;
	import biq_pkg::*;

	// Extremes of the 56-bit Q.20 state.
	localparam longint STATE_MAX = 64'sh007F_FFFF_FFFF_FFFF;
	localparam longint STATE_MIN = -STATE_MAX - 1;

	// Indexes past the register list; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [COEF_BITS-1:0] b0;
		logic [COEF_BITS-1:0] b1;
		logic [COEF_BITS-1:0] b2;
		logic [COEF_BITS-1:0] a1;
		logic [COEF_BITS-1:0] a2;
	} section_coefs_t;

	typedef enum {STYLE_STABLE, STYLE_RAW, STYLE_CORNER, STYLE_GAIN} coef_style_t;

	typedef struct {
		logic [SAMPLE_W-1:0] sample;
		logic                last;
		logic                clip;
	} filter_result_t;

	class cascade_scoreboard;
		logic signed [COEF_BITS-1:0] b0 [SECTIONS];
		logic signed [COEF_BITS-1:0] b1 [SECTIONS];
		logic signed [COEF_BITS-1:0] b2 [SECTIONS];
		logic signed [COEF_BITS-1:0] a1 [SECTIONS];
		logic signed [COEF_BITS-1:0] a2 [SECTIONS];
		longint delay_near [SECTIONS];
		longint delay_far [SECTIONS];
		bit clipped;
		filter_result_t pending_outputs [$];
		int errors;
		int results_seen;

		// Reset state: every section passes its input through unchanged.
		function new();
			for (int s = 0; s < SECTIONS; s++) begin
				b0[s] = COEF_ONE;
				b1[s] = '0;
				b2[s] = '0;
				a1[s] = '0;
				a2[s] = '0;
				delay_near[s] = 0;
				delay_far[s] = 0;
			end
			errors = 0;
			results_seen = 0;
		endfunction

		// Mirror an accepted coefficient write.
		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			int s;
			s = (idx >= CFG_SEC1_B0_B1) ? 1 : 0;
			case (idx)
				CFG_SEC0_B0_B1, CFG_SEC1_B0_B1: {b0[s], b1[s]} = data;
				CFG_SEC0_B2_A1, CFG_SEC1_B2_A1: {b2[s], a1[s]} = data;
				CFG_SEC0_A2, CFG_SEC1_A2: a2[s] = data[COEF_BITS-1:0];
				default: ;
			endcase
		endfunction

		function longint clip_state(longint v);
			if (v > STATE_MAX) begin
				clipped = 1'b1;
				return STATE_MAX;
			end
			if (v < STATE_MIN) begin
				clipped = 1'b1;
				return STATE_MIN;
			end
			return v;
		endfunction

		// Coefficient times a Q.20 value: magnitude product shifted down, then clipped.
		function longint scaled_product(logic signed [COEF_BITS-1:0] c, longint v);
			logic neg;
			longint unsigned cm, vm;
			logic [127:0] p, lim;
			neg = (c < 0) != (v < 0);
			cm = (c < 0) ? -longint'(c) : longint'(c);
			vm = (v < 0) ? -v : v;
			p = (128'(cm) * 128'(vm)) >> FRAC_BITS;
			lim = neg ? 128'(STATE_MAX) + 128'd1 : 128'(STATE_MAX);
			if (p > lim) begin
				clipped = 1'b1;
				p = lim;
			end
			return neg ? -$signed(p[63:0]) : $signed(p[63:0]);
		endfunction

		// Run one sample through the cascade and queue the output it must produce.
		function void filter_sample(logic [SAMPLE_W-1:0] s, logic last);
			filter_result_t r;
			longint x, y, iv;
			longint unsigned m;
			logic neg;
			clipped = 1'b0;
			x = longint'($signed(s)) * (64'sd1 <<< FRAC_BITS);
			for (int k = 0; k < SECTIONS; k++) begin
				y = clip_state(scaled_product(b0[k], x) + delay_near[k]);
				delay_near[k] = clip_state(scaled_product(b1[k], x)
					- scaled_product(a1[k], y) + delay_far[k]);
				delay_far[k] = clip_state(scaled_product(b2[k], x) - scaled_product(a2[k], y));
				x = y;
			end
			// Truncate toward zero, then clip to the 32-bit range.
			neg = x < 0;
			m = (neg ? -x : x) >> FRAC_BITS;
			if (neg && m > 64'd2147483648) begin
				clipped = 1'b1;
				m = 64'd2147483648;
			end else if (!neg && m > 64'd2147483647) begin
				clipped = 1'b1;
				m = 64'd2147483647;
			end
			iv = neg ? -longint'(m) : longint'(m);
			r.sample = iv[SAMPLE_W-1:0];
			r.last = last;
			r.clip = clipped;
			pending_outputs.push_back(r);
		endfunction

		function int pending();
			return pending_outputs.size();
		endfunction

		task report_mismatch(string what, logic [SAMPLE_W-1:0] got, logic [SAMPLE_W-1:0] want);
			errors++;
			if (errors <= 100)
				$display("output %0d: %s is %h, should be %h", results_seen, what, got, want);
		endtask

		// Compare one accepted output with the oldest prediction.
		task check_output(logic [SAMPLE_W-1:0] s, logic last, logic sat);
			filter_result_t want;
			results_seen++;
			if (pending_outputs.size() == 0) begin
				report_mismatch("output with nothing pending", s, '0);
				return;
			end
			want = pending_outputs.pop_front();
			if (s !== want.sample)
				report_mismatch("sample_out", s, want.sample);
			if (last !== want.last)
				report_mismatch("block_last_out", SAMPLE_W'(last), SAMPLE_W'(want.last));
			if (sat !== want.clip)
				report_mismatch("saturated", SAMPLE_W'(sat), SAMPLE_W'(want.clip));
		endtask
	endclass

endpackage

// ===== sim/tb_biquad_cascade_iir_filter.sv =====
// Testbench top of the biquad cascade filter: stimulus, stall patterns and result checks.
module tb_biquad_cascade_iir_filter;
	import biq_pkg::*;
	import biquad_check_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT       = 1000000;
	localparam int LONG_HOLD   = 400;
	localparam int IDLE_GAP    = 100;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 106;

	localparam logic [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic [COEF_BITS-1:0] COEF_HALF = COEF_ONE >> 1;

	typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [SAMPLE_W-1:0]   sample_in;
	logic                  block_last;
	logic                  out_valid;
	logic                  out_stall;
	logic [SAMPLE_W-1:0]   sample_out;
	logic                  block_last_out;
	logic                  saturated;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cascade_scoreboard sb;
	int burst_left;
	int hold_requests;
	int cycle_count;

	biquad_cascade_iir_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sample_in(sample_in),
		.block_last(block_last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sample_out(sample_out),
		.block_last_out(block_last_out),
		.saturated(saturated),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up if the run takes far longer than the slowest correct one.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// Check every output request the filter hands over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_output(sample_out, block_last_out, saturated);
	end

	// Receiver stalls: modes of random length, plus a long hold-off when asked for.
	initial begin
		stall_mode_t mode;
		int mode_left, hold_left, hold_seen;
		out_stall = 1'b0;
		mode = STALL_NONE;
		mode_left = 0;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(negedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = stall_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(20, 200);
				end
				mode_left--;
				case (mode)
					STALL_NONE: out_stall <= 1'b0;
					STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
					STALL_PERIODIC: out_stall <= (mode_left % 5) < 2;
					default: out_stall <= $urandom_range(0, 3) != 0;
				endcase
			end
		end
	end

	// Offer one sample request; after it is taken, either keep the burst going or idle.
	task send_item(input logic [SAMPLE_W-1:0] s, input logic last);
		in_valid <= 1'b1;
		sample_in <= s;
		block_last <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.filter_sample(s, last);
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(negedge clk);
			burst_left = $urandom_range(0, 40);
		end
	endtask

	// One configuration write; the caller lowers valid after the last one.
	task drive_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.load_register(idx, data);
		@(negedge clk);
	endtask

	// Load both sections; the unused upper bits of the a2 registers and the spare indexes
	// get random data.
	task program_filter(input section_coefs_t sc0, input section_coefs_t sc1);
		drive_reg(CFG_SEC0_B0_B1, {sc0.b0, sc0.b1});
		drive_reg(CFG_SEC0_B2_A1, {sc0.b2, sc0.a1});
		drive_reg(CFG_SEC0_A2, {COEF_BITS'($urandom), sc0.a2});
		drive_reg(CFG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
		drive_reg(CFG_SEC1_B0_B1, {sc1.b0, sc1.b1});
		drive_reg(CFG_SEC1_B2_A1, {sc1.b2, sc1.a1});
		drive_reg(CFG_SEC1_A2, {COEF_BITS'($urandom), sc1.a2});
		drive_reg(CFG_SPARE_HI, CFG_DATA_W'({$urandom, $urandom}));
		cfg_valid <= 1'b0;
	endtask

	// Stop offering and let every predicted output come out before touching registers.
	task wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (IDLE_GAP) @(negedge clk);
	endtask

	function automatic logic [COEF_BITS-1:0] corner_coef();
		case ($urandom_range(0, 4))
			0: return COEF_MAX;
			1: return COEF_MIN;
			2: return '0;
			3: return COEF_ONE;
			default: return -COEF_ONE;
		endcase
	endfunction

	// Stable sections keep |a2| < 1 and |a1| < 1 + a2, so the state stays bounded.
	function automatic section_coefs_t random_section(input coef_style_t style);
		section_coefs_t c;
		c = '0;
		case (style)
			STYLE_STABLE: begin
				c.a2 = COEF_BITS'(int'($urandom_range(0, 'hC0000)) - 32'sh40000);
				c.a1 = COEF_BITS'(int'($urandom_range(0, 'h140000)) - 32'shA0000);
				c.b0 = COEF_BITS'(int'($urandom_range(0, 'h200000)) - 32'sh100000);
				c.b1 = COEF_BITS'(int'($urandom_range(0, 'h200000)) - 32'sh100000);
				c.b2 = COEF_BITS'(int'($urandom_range(0, 'h200000)) - 32'sh100000);
			end
			STYLE_RAW: begin
				c.b0 = COEF_BITS'($urandom);
				c.b1 = COEF_BITS'($urandom);
				c.b2 = COEF_BITS'($urandom);
				c.a1 = COEF_BITS'($urandom);
				c.a2 = COEF_BITS'($urandom);
			end
			STYLE_CORNER: begin
				c.b0 = corner_coef();
				c.b1 = corner_coef();
				c.b2 = corner_coef();
				c.a1 = corner_coef();
				c.a2 = corner_coef();
			end
			default: begin
				c.b0 = COEF_BITS'(int'($urandom_range(0, 'h400000)) - 32'sh200000);
			end
		endcase
		return c;
	endfunction

	// Mostly full-range samples, with small values and the extremes mixed in.
	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 19))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2, 3, 4, 5, 6: return SAMPLE_W'(int'($urandom_range(0, 8191)) - 4096);
			default: return $urandom;
		endcase
	endfunction

	initial begin
		section_coefs_t sc0, sc1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		block_last = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_requests = 0;
		cycle_count = 0;
		burst_left = $urandom_range(0, 40);
		sb = new();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset coefficients pass samples through unchanged.
		send_item(32'h0000_0000, 1'b0);
		send_item(32'h0000_0001, 1'b0);
		send_item(32'hFFFF_FFFF, 1'b1);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h5555_5555, 1'b0);
		send_item(32'hAAAA_AAAA, 1'b1);
		send_item(32'd12345, 1'b0);
		send_item(-32'sd12345, 1'b0);

		// Extreme coefficients: products, delays, section and final outputs all clip.
		wait_idle();
		sc0 = {COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
		sc1 = {COEF_MAX, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN};
		program_filter(sc0, sc1);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h7FFF_FFFF, 1'b0);
		send_item(32'h8000_0000, 1'b0);
		send_item(32'h0000_0000, 1'b1);
		send_item(32'h0000_0001, 1'b0);

		// Half gain: odd negative samples show truncation toward zero.
		wait_idle();
		sc0 = '0;
		sc0.b0 = COEF_HALF;
		sc1 = '0;
		sc1.b0 = COEF_ONE;
		program_filter(sc0, sc1);
		send_item(-32'sd3, 1'b0);
		send_item(32'd3, 1'b1);
		send_item(-32'sd1, 1'b0);
		send_item(32'd1, 1'b0);
		send_item(32'h8000_0000, 1'b1);
		send_item(32'h7FFF_FFFF, 1'b0);

		// Random filters, one coefficient style per phase; one phase holds the output off.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_idle();
			program_filter(random_section(coef_style_t'(ph % 4)),
				random_section(coef_style_t'(ph % 4)));
			if (ph == 2)
				hold_requests <= hold_requests + 1;
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_item(random_sample(), $urandom_range(0, 7) == 0);
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/biq_pkg.sv
rtl/core/biq_coef_regs.sv
rtl/core/biq_mul.sv
rtl/core/biq_delay_mem.sv
rtl/core/biquad_cascade_iir_filter.sv
sim/biquad_check_pkg.sv
sim/tb_biquad_cascade_iir_filter.sv
